// ===== design/assert_macros.svh =====
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is low.
`define DFQ_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("port check failed");

// Same, with a caller-supplied message.
`define DFQ_ASSERT_MSG(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

`endif

// ===== design/dfq_pkg.sv =====
// Shared types and codes for the dual thread-id queue block.
package dfq_pkg;

	localparam int IN_TDATA_W  = 24;
	localparam int IN_TUSER_W  = 1;
	localparam int OUT_TDATA_W = 24;
	localparam int OUT_ID_W    = 16;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_POP    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_SEARCH = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic load_req;
		logic do_append;
		logic scan_en;
		logic hit_take;
		logic scan_miss;
		logic shift_en;
		logic shift_finish;
		logic out_load;
	} dfq_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_append;
		logic is_search;
		logic hit;
		logic scan_done;
		logic shift_done;
		logic out_free;
	} dfq_stat_t;

endpackage

// ===== design/dual_fifo_queue_with_remove_by_id_top.sv =====
// Top level of the dual thread-id queue with append, pop, remove and search.
//
//  channel  dir  bits   contents (low bit up)
//  s_axis   in   24+1   tdata: op[1:0], thread_id[17:2]; tuser: queue_sel
//  m_axis   out  24     tdata: result_id[15:0], status[17:16]
//
// One request is in flight at a time; s_axis_tready is high only between requests.
// Steps per request: append writes the tail; search scans to the match or to the fill;
// pop/remove scan to the match, then shift the later entries down
// one entry per cycle over the single RAM port.
// The scan and shift loops run through the one-read/one-write entry RAM.
// Reset clears both fill counts; stored entries are not cleared and never read past the fill.
// A result held by m_axis_tready low stalls only the finish step; the next
// request is still taken once the previous result is in the output register.
module dual_fifo_queue_with_remove_by_id_top
	import dfq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // op[1:0], thread_id[17:2], zero pad
	input  logic [IN_TUSER_W-1:0]  s_axis_tuser,   // queue_sel[0]
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata    // result_id[15:0], status[17:16], zero pad
);

	dfq_cmd_t            cmd;
	dfq_stat_t           stat;
	logic [OUT_ID_W-1:0] out_result_id;
	status_t             out_status;

	// sequencer: owns the handshake on the input side
	dfq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// storage, counts and the output register
	dfq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ID_BITS     (ID_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.req_op        (op_t'(s_axis_tdata[1:0])),
		.req_queue     (s_axis_tuser[0]),
		.req_thread_id (s_axis_tdata[17:2]),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_result_id (out_result_id),
		.out_status    (out_status)
	);

	assign m_axis_tdata = OUT_TDATA_W'({out_status, out_result_id});

endmodule

// ===== design/dfq_ctrl.sv =====
// Request sequencer: dispatch, scan, shift and result hand-off.
module dfq_ctrl
	import dfq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  dfq_stat_t stat,
	output dfq_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_SCAN,
		S_SHIFT,
		S_FIN
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: cmd.load_req = in_valid;
			S_START: cmd.do_append = stat.is_append;
			S_SCAN: begin
				cmd.scan_en   = 1'b1;
				cmd.hit_take  = stat.hit;
				cmd.scan_miss = stat.scan_done;
			end
			S_SHIFT: begin
				cmd.shift_en     = 1'b1;
				cmd.shift_finish = stat.shift_done;
			end
			S_FIN: cmd.out_load = stat.out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_START;
				S_START: state_q <= stat.is_append ? S_FIN : S_SCAN;
				S_SCAN: begin
					if (stat.hit) begin
						state_q <= stat.is_search ? S_FIN : S_SHIFT;
					end else if (stat.scan_done) begin
						state_q <= S_FIN;
					end
				end
				S_SHIFT: if (stat.shift_done) state_q <= S_FIN;
				S_FIN: if (stat.out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== design/dfq_dp.sv =====
// Queue storage, fill counts, scan/shift pipelines and result registers.
module dfq_dp
	import dfq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dfq_cmd_t            cmd,
	output dfq_stat_t           stat,
	input  op_t                 req_op,
	input  logic                req_queue,
	input  logic [OUT_ID_W-1:0] req_thread_id,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [OUT_ID_W-1:0] out_result_id,
	output status_t             out_status
);

	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int CW    = (ID_BITS < OUT_ID_W) ? ID_BITS : OUT_ID_W;
	localparam int MEM_N = 2 ** (IDX_W + 1);

	logic [ID_BITS-1:0] mem [MEM_N];

	op_t                 op_q;
	logic                q_q;
	logic [ID_BITS-1:0]  key_q;
	logic [CNT_W-1:0]    count_q [2];
	logic [CNT_W-1:0]    rd_idx_q;
	logic [CNT_W-1:0]    sh_rd_q;
	logic                scan_pend_s1;
	logic [IDX_W-1:0]    scan_pos_s1;
	logic                sh_pend_s1;
	logic [IDX_W-1:0]    sh_wr_s1;
	logic [ID_BITS-1:0]  rdata_q;
	logic [ID_BITS-1:0]  res_id_q;
	status_t             res_st_q;
	logic                out_valid_q;
	logic [OUT_ID_W-1:0] out_id_q;
	status_t             out_st_q;

	logic [CNT_W-1:0] cur_count;
	logic [CNT_W-1:0] rd_sel;
	logic             scan_issue;
	logic             shift_issue;
	logic             append_ok;
	logic             wr_en;
	logic [IDX_W:0]   wr_addr;
	logic [ID_BITS-1:0] wr_data;

	assign cur_count   = count_q[q_q];
	assign scan_issue  = cmd.scan_en && (rd_idx_q < cur_count);
	assign shift_issue = cmd.shift_en && (sh_rd_q < cur_count);
	assign rd_sel      = cmd.shift_en ? sh_rd_q : rd_idx_q;
	assign append_ok   = cur_count < CNT_W'(QUEUE_DEPTH);

	// one write port: shift copy or tail append, never both
	assign wr_en   = (cmd.do_append && append_ok) || sh_pend_s1;
	assign wr_addr = sh_pend_s1 ? {q_q, sh_wr_s1} : {q_q, cur_count[IDX_W-1:0]};
	assign wr_data = sh_pend_s1 ? rdata_q : key_q;

	assign stat.is_append  = (op_q == OP_APPEND);
	assign stat.is_search  = (op_q == OP_SEARCH);
	assign stat.hit        = scan_pend_s1 && ((op_q == OP_POP) || (rdata_q == key_q));
	assign stat.scan_done  = !scan_pend_s1 && (rd_idx_q >= cur_count);
	assign stat.shift_done = !sh_pend_s1 && (sh_rd_q >= cur_count);
	assign stat.out_free   = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[{q_q, rd_sel[IDX_W-1:0]}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q[0]   <= '0;
			count_q[1]   <= '0;
			scan_pend_s1 <= 1'b0;
			sh_pend_s1   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			scan_pend_s1 <= scan_issue;
			sh_pend_s1   <= shift_issue;
			if (cmd.do_append && append_ok) begin
				count_q[q_q] <= cur_count + CNT_W'(1);
			end else if (cmd.shift_finish) begin
				count_q[q_q] <= cur_count - CNT_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			op_q     <= req_op;
			q_q      <= req_queue;
			key_q    <= ID_BITS'(req_thread_id[CW-1:0]);
			rd_idx_q <= '0;
		end
		if (scan_issue) begin
			rd_idx_q    <= rd_idx_q + CNT_W'(1);
			scan_pos_s1 <= rd_idx_q[IDX_W-1:0];
		end
		if (shift_issue) begin
			sh_rd_q  <= sh_rd_q + CNT_W'(1);
			sh_wr_s1 <= sh_rd_q[IDX_W-1:0] - IDX_W'(1);
		end
		if (cmd.do_append) begin
			res_id_q <= append_ok ? key_q : '0;
			res_st_q <= append_ok ? ST_OK : ST_FULL;
		end
		if (cmd.hit_take) begin
			res_id_q <= rdata_q;
			res_st_q <= ST_OK;
			sh_rd_q  <= CNT_W'(scan_pos_s1) + CNT_W'(1);
		end
		if (cmd.scan_miss) begin
			res_id_q <= '0;
			res_st_q <= ST_MISS;
		end
		if (cmd.out_load) begin
			out_id_q <= OUT_ID_W'(res_id_q[CW-1:0]);
			out_st_q <= res_st_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_result_id = out_id_q;
	assign out_status    = out_st_q;

endmodule

// ===== design/dfq_checker.sv =====
// Port-level checks for the dual thread-id queue, bound to the top level.
`include "assert_macros.svh"

module dfq_checker
	import dfq_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	logic in_acc;

	assign in_acc = s_axis_tvalid && s_axis_tready;

	// a stalled result stays offered
	`DFQ_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)

	// one request at a time: no new transaction right after one is taken
	`DFQ_ASSERT_MSG(a_one_in_flight, in_acc |=> !s_axis_tready, "second request taken")

	// no result can appear the cycle after a request is taken
	`DFQ_ASSERT_MSG(a_min_latency, in_acc |=> !$rose(m_axis_tvalid), "result too early")

	// refused or missed requests report id zero
	`DFQ_ASSERT(a_fail_id_zero,
		m_axis_tvalid && (m_axis_tdata[17:16] != 2'(ST_OK)) |-> (m_axis_tdata[15:0] == 16'd0))

endmodule

bind dual_fifo_queue_with_remove_by_id_top dfq_checker u_dfq_checker (.*);
